### hdl/playfair_digraph_cipher_top_defines.svh
// ---------------------------------------------------------------------------
// playfair digraph cipher assertion macros
// shared property wrappers for the checker, clocked on clk, quiet in reset
// ---------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_TOP_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_TOP_DEFINES_SVH

// same-cycle implication
`define PDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pdc_pkg.sv
// ---------------------------------------------------------------------------
// pdc_pkg
// shared types and constants of the playfair digraph cipher
// ---------------------------------------------------------------------------
package pdc_pkg;

  localparam int SQUARE_SIDE    = 5;
  localparam int LETTER_BITS    = 5;
  localparam int ROW_BITS       = SQUARE_SIDE * LETTER_BITS;
  localparam int CELLS          = SQUARE_SIDE * SQUARE_SIDE;
  localparam int REG_INDEX_BITS = 3;

  typedef logic [LETTER_BITS-1:0] letter_t;
  typedef logic [ROW_BITS-1:0]    row_t;
  typedef logic [SQUARE_SIDE-1:0] pos_oh_t;
  typedef logic [CELLS-1:0]       cell_oh_t;

  // opcode values
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

endpackage

### hdl/playfair_digraph_cipher_top.sv
// ---------------------------------------------------------------------------
// playfair digraph cipher
// one letter pair in, one transformed pair out, against a 5x5 key square
// ---------------------------------------------------------------------------
// The block takes one letter pair per request and returns both transformed
// letters together. A new request is taken every cycle while in_ready is
// high: an input register feeds the square lookup and transform logic,
// which loads the result register. in_ready only drops when a finished
// result waits on out_ready and the input register is full. Key square
// rows are written on the cfg port (index 0..4, column 0 in the low bits);
// writes to other indexes are ignored. Each letter is located
// by 25 parallel comparators with the first match in row-major order winning.
// Same row shifts columns right (encrypt) or left (decrypt), same column
// shifts rows down or up, otherwise the two columns are swapped. If either
// letter is absent the result has not_found set and both letters zero.
// ---------------------------------------------------------------------------
module playfair_digraph_cipher_top (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_we,
  input  logic [pdc_pkg::REG_INDEX_BITS-1:0]    cfg_index,
  input  logic [pdc_pkg::ROW_BITS-1:0]          cfg_data,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  opcode,
  input  logic [pdc_pkg::LETTER_BITS-1:0]       first_letter,
  input  logic [pdc_pkg::LETTER_BITS-1:0]       second_letter,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [pdc_pkg::LETTER_BITS-1:0]       first_result,
  output logic [pdc_pkg::LETTER_BITS-1:0]       second_result,
  output logic                                  not_found
);

  localparam int S = pdc_pkg::SQUARE_SIDE;
  localparam int L = pdc_pkg::LETTER_BITS;
  localparam int N = pdc_pkg::CELLS;

  // lowest set bit, i.e. first match in row-major order
  function automatic pdc_pkg::cell_oh_t first_hit(input pdc_pkg::cell_oh_t m);
    return m & (~m + N'(1));
  endfunction

  function automatic pdc_pkg::pos_oh_t row_of(input pdc_pkg::cell_oh_t oh);
    pdc_pkg::pos_oh_t r;
    for (int i = 0; i < S; i++) begin
      r[i] = |oh[i*S +: S];
    end
    return r;
  endfunction

  function automatic pdc_pkg::pos_oh_t col_of(input pdc_pkg::cell_oh_t oh);
    pdc_pkg::pos_oh_t c;
    c = '0;
    for (int i = 0; i < S; i++) begin
      for (int j = 0; j < S; j++) begin
        c[j] = c[j] | oh[i*S + j];
      end
    end
    return c;
  endfunction

  // one step forward (encrypt) or back (decrypt), wrapping
  function automatic pdc_pkg::pos_oh_t rotate(input pdc_pkg::pos_oh_t p,
                                              input logic op);
    if (op == pdc_pkg::OP_DECRYPT) begin
      return {p[0], p[S-1:1]};
    end
    return {p[S-2:0], p[S-1]};
  endfunction

  // and-or select of the entry at a one-hot row and column
  function automatic pdc_pkg::letter_t pick(
    input pdc_pkg::pos_oh_t                  r,
    input pdc_pkg::pos_oh_t                  c,
    input logic [N-1:0][L-1:0]               codes
  );
    pdc_pkg::letter_t v;
    v = '0;
    for (int i = 0; i < S; i++) begin
      for (int j = 0; j < S; j++) begin
        v = v | (codes[i*S + j] & {L{r[i] & c[j]}});
      end
    end
    return v;
  endfunction

  // key square rows
  pdc_pkg::row_t square_row [S];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < S; i++) begin
        square_row[i] <= '0;
      end
    end else if (cfg_we) begin
      for (int i = 0; i < S; i++) begin
        if (cfg_index == pdc_pkg::REG_INDEX_BITS'(i)) begin
          square_row[i] <= cfg_data;
        end
      end
    end
  end

  // flattened row-major view of the square
  logic [N-1:0][L-1:0] cell_code;

  always_comb begin
    for (int i = 0; i < S; i++) begin
      for (int j = 0; j < S; j++) begin
        cell_code[i*S + j] = square_row[i][j*L +: L];
      end
    end
  end

  // input register
  logic             s1_valid;
  logic             s1_opcode;
  pdc_pkg::letter_t s1_first;
  pdc_pkg::letter_t s1_second;
  logic             out_load;

  // result register loads whenever the input register is full and the result register is empty or being drained
  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_opcode <= opcode;
      s1_first  <= first_letter;
      s1_second <= second_letter;
    end
  end

  // lookup: parallel compare against every entry
  pdc_pkg::cell_oh_t match1, match2;
  pdc_pkg::cell_oh_t hit1, hit2;
  pdc_pkg::pos_oh_t  r1, c1, r2, c2;
  pdc_pkg::pos_oh_t  r1_next, c1_next, r2_next, c2_next;
  logic              found;
  pdc_pkg::letter_t  first_next, second_next;

  always_comb begin
    for (int p = 0; p < N; p++) begin
      match1[p] = (cell_code[p] == s1_first);
      match2[p] = (cell_code[p] == s1_second);
    end
    hit1  = first_hit(match1);
    hit2  = first_hit(match2);
    found = (|match1) && (|match2);
    r1    = row_of(hit1);
    c1    = col_of(hit1);
    r2    = row_of(hit2);
    c2    = col_of(hit2);

    // digraph rules: same row, then same column, then rectangle
    r1_next = r1;
    r2_next = r2;
    c1_next = c2;
    c2_next = c1;
    if (r1 == r2) begin
      c1_next = rotate(c1, s1_opcode);
      c2_next = rotate(c2, s1_opcode);
    end else if (c1 == c2) begin
      r1_next = rotate(r1, s1_opcode);
      r2_next = rotate(r2, s1_opcode);
      c1_next = c1;
      c2_next = c2;
    end

    first_next  = found ? pick(r1_next, c1_next, cell_code) : '0;
    second_next = found ? pick(r2_next, c2_next, cell_code) : '0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      first_result  <= first_next;
      second_result <= second_next;
      not_found     <= !found;
    end
  end

endmodule

### hdl/pdc_checker.sv
// ---------------------------------------------------------------------------
// pdc_checker
// port-level checks of the playfair digraph cipher, bound to the top level
// ---------------------------------------------------------------------------
`include "playfair_digraph_cipher_top_defines.svh"

module pdc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [pdc_pkg::LETTER_BITS-1:0] first_result,
  input logic [pdc_pkg::LETTER_BITS-1:0] second_result,
  input logic                            not_found
);

  // an offered request stays offered until taken
  `PDC_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid, "request withdrawn before accept")

  // a result stays offered until taken
  `PDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // a stalled result keeps its payload
  `PDC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(first_result) && $stable(second_result) && $stable(not_found), "stalled result changed")

  // a missing letter forces both result letters to zero
  `PDC_ASSERT_NOW(a_missing_zero, out_valid && not_found, first_result == '0 && second_result == '0, "letters nonzero on not_found")

  // backpressure on the request side only comes from a held result
  `PDC_ASSERT_NOW(a_ready_backpressure, !in_ready, out_valid && !out_ready, "in_ready low without a stalled result")

endmodule

bind playfair_digraph_cipher_top pdc_checker u_pdc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .first_result  (first_result),
  .second_result (second_result),
  .not_found     (not_found)
);

### verif/pdc_pair_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdc_pair_checker
// watches the config, request and result channels of the playfair cipher,
// predicts each transformed letter pair and compares it with the block
// ---------------------------------------------------------------------------
module pdc_pair_checker
  import pdc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [REG_INDEX_BITS-1:0] cfg_index,
  input  row_t                      cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      opcode,
  input  letter_t                   first_letter,
  input  letter_t                   second_letter,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  letter_t                   first_result,
  input  letter_t                   second_result,
  input  logic                      not_found,
  output int                        mismatches,
  output int                        pending_pairs
);

  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    missing;
  } cipher_pair_t;

  row_t         key_rows [SQUARE_SIDE];
  cipher_pair_t expected_pairs [$];
  int           error_total = 0;

  function automatic letter_t square_cell(int r, int c);
    return key_rows[r][c*LETTER_BITS +: LETTER_BITS];
  endfunction

  // first match in row-major order wins
  function automatic void find_letter(input letter_t l, output bit hit,
                                      output int r, output int c);
    hit = 1'b0;
    r   = 0;
    c   = 0;
    for (int i = 0; i < CELLS; i++) begin
      if (!hit && square_cell(i / SQUARE_SIDE, i % SQUARE_SIDE) == l) begin
        hit = 1'b1;
        r   = i / SQUARE_SIDE;
        c   = i % SQUARE_SIDE;
      end
    end
  endfunction

  function automatic cipher_pair_t cipher_pair(logic op, letter_t a, letter_t b);
    cipher_pair_t res;
    bit           hit_a, hit_b;
    int           r1, c1, r2, c2, held_col, shift;
    shift = (op == OP_DECRYPT) ? SQUARE_SIDE - 1 : 1;
    find_letter(a, hit_a, r1, c1);
    find_letter(b, hit_b, r2, c2);
    res = '0;
    if (!(hit_a && hit_b)) begin
      res.missing = 1'b1;
      return res;
    end
    if (r1 == r2) begin
      c1 = (c1 + shift) % SQUARE_SIDE;
      c2 = (c2 + shift) % SQUARE_SIDE;
    end else if (c1 == c2) begin
      r1 = (r1 + shift) % SQUARE_SIDE;
      r2 = (r2 + shift) % SQUARE_SIDE;
    end else begin
      held_col = c1;
      c1       = c2;
      c2       = held_col;
    end
    res.first  = square_cell(r1, c1);
    res.second = square_cell(r2, c2);
    return res;
  endfunction

  always @(posedge clk) begin
    cipher_pair_t want;
    if (rst) begin
      foreach (key_rows[i]) key_rows[i] = '0;
      expected_pairs.delete();
    end else begin
      // indexes past the last row are ignored by the block
      if (cfg_we && cfg_index < SQUARE_SIDE) key_rows[cfg_index] = cfg_data;
      if (in_valid && in_ready)
        expected_pairs.push_back(cipher_pair(opcode, first_letter, second_letter));
      if (out_valid && out_ready) begin
        if (expected_pairs.size() == 0) begin
          $error("result with no request pending: first_result %0d second_result %0d not_found %0d",
                 first_result, second_result, not_found);
          error_total++;
        end else begin
          want = expected_pairs.pop_front();
          if (first_result !== want.first) begin
            $error("first_result mismatch: expected %0d, actual %0d", want.first, first_result);
            error_total++;
          end
          if (second_result !== want.second) begin
            $error("second_result mismatch: expected %0d, actual %0d",
                   want.second, second_result);
            error_total++;
          end
          if (not_found !== want.missing) begin
            $error("not_found mismatch: expected %0d, actual %0d", want.missing, not_found);
            error_total++;
          end
        end
      end
    end
    pending_pairs <= expected_pairs.size();
    mismatches    <= error_total;
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// drives letter pairs through the playfair cipher under a series of key
// squares (reset, classic, all ones, all zero, random) with random gaps on
// both channels and one long result hold-off; the checker scores the results
// ---------------------------------------------------------------------------
module tb;
  import pdc_pkg::*;

  localparam int      CLK_HALF         = 6;
  localparam int      RESET_CYCLES     = 8;
  // extra drain time after the last result before touching config
  localparam int      DRAIN_CYCLES     = 6;
  localparam int      RANDOM_PHASES    = 8;
  localparam int      PHASE_PAIRS      = 115;
  localparam int      BURST_PAIRS      = 40;
  localparam int      SINK_HOLD_CYCLES = 120;
  localparam int      TIMEOUT_NS       = 6_000_000;
  localparam letter_t LAST_LETTER      = 5'd25;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_ROW_ZERO  = 3'd0,
    REG_ROW_ONE   = 3'd1,
    REG_ROW_TWO   = 3'd2,
    REG_ROW_THREE = 3'd3,
    REG_ROW_FOUR  = 3'd4,
    REG_UNUSED    = 3'd7
  } reg_index_e;

  typedef enum {KEY_CLASSIC, KEY_REPEATS, KEY_RAW} key_kind_e;
  typedef enum {PAIR_ROW, PAIR_COLUMN, PAIR_ANY} pair_shape_e;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [REG_INDEX_BITS-1:0] cfg_index;
  row_t                      cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      opcode;
  letter_t                   first_letter;
  letter_t                   second_letter;
  logic                      out_valid;
  logic                      out_ready;
  letter_t                   first_result;
  letter_t                   second_result;
  logic                      not_found;
  int                        mismatches;
  int                        pending_pairs;

  // current key square as the stimulus sees it, row-major
  letter_t    key_cells [CELLS];
  reg_index_e row_regs [SQUARE_SIDE] = '{REG_ROW_ZERO, REG_ROW_ONE, REG_ROW_TWO,
                                         REG_ROW_THREE, REG_ROW_FOUR};
  // sender runs without gaps while set
  bit         steady_sender = 1'b0;
  // asks the result side for one long hold-off
  bit         sink_hold_req = 1'b0;

  playfair_digraph_cipher_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .first_letter  (first_letter),
    .second_letter (second_letter),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .first_result  (first_result),
    .second_result (second_result),
    .not_found     (not_found)
  );

  pdc_pair_checker u_pair_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .first_letter  (first_letter),
    .second_letter (second_letter),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .first_result  (first_result),
    .second_result (second_result),
    .not_found     (not_found),
    .mismatches    (mismatches),
    .pending_pairs (pending_pairs)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ascii capital to letter code
  function automatic letter_t ch(byte c);
    return letter_t'(c - 8'd65);
  endfunction

  // fill key_cells with a fresh square of the given flavor
  function automatic void pick_square(key_kind_e kind);
    letter_t pool [LAST_LETTER+1];
    letter_t swap_tmp;
    int      j;
    for (int i = 0; i <= LAST_LETTER; i++) pool[i] = letter_t'(i);
    // shuffle all 26 letters, the one left over is missing from the square
    for (int i = LAST_LETTER; i > 0; i--) begin
      j        = $urandom_range(0, i);
      swap_tmp = pool[i];
      pool[i]  = pool[j];
      pool[j]  = swap_tmp;
    end
    for (int i = 0; i < CELLS; i++) begin
      case (kind)
        KEY_CLASSIC: key_cells[i] = pool[i];
        KEY_REPEATS: key_cells[i] = letter_t'($urandom_range(0, LAST_LETTER));
        default:     key_cells[i] = letter_t'($urandom_range(0, (1 << LETTER_BITS) - 1));
      endcase
    end
  endfunction

  // one config write, cfg_we is left high for the caller to drop
  task automatic write_reg(reg_index_e idx, row_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // push key_cells into the five row registers, column 0 in the low bits
  task automatic load_square();
    row_t row;
    for (int r = 0; r < SQUARE_SIDE; r++) begin
      row = '0;
      for (int c = 0; c < SQUARE_SIDE; c++)
        row[c*LETTER_BITS +: LETTER_BITS] = key_cells[r*SQUARE_SIDE + c];
      write_reg(row_regs[r], row);
    end
    cfg_we <= 1'b0;
  endtask

  // offer one request, hold it until taken, then maybe idle
  task automatic send_pair(logic op, letter_t a, letter_t b);
    int gap;
    in_valid      <= 1'b1;
    opcode        <= op;
    first_letter  <= a;
    second_letter <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = steady_sender ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // pairs are mostly drawn from the square, biased toward shared rows and
  // columns, with some plain random letters mixed in
  task automatic send_random_pair();
    int          i1, i2;
    pair_shape_e shape;
    letter_t     a, b;
    i1    = $urandom_range(0, CELLS - 1);
    shape = pair_shape_e'($urandom_range(0, 2));
    case (shape)
      PAIR_ROW:    i2 = (i1 / SQUARE_SIDE) * SQUARE_SIDE + $urandom_range(0, SQUARE_SIDE - 1);
      PAIR_COLUMN: i2 = $urandom_range(0, SQUARE_SIDE - 1) * SQUARE_SIDE + i1 % SQUARE_SIDE;
      default:     i2 = $urandom_range(0, CELLS - 1);
    endcase
    a = key_cells[i1];
    b = key_cells[i2];
    if (a > LAST_LETTER || $urandom_range(0, 9) == 0) a = letter_t'($urandom_range(0, LAST_LETTER));
    if (b > LAST_LETTER || $urandom_range(0, 9) == 0) b = letter_t'($urandom_range(0, LAST_LETTER));
    send_pair($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, a, b);
  endtask

  // drop valid and wait for every request to come back before config changes
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pairs != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: ready bursts and random stalls, plus one long hold-off on request
  initial begin
    int burst, stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        out_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold_req = 1'b0;
      end else begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
        out_ready <= 1'b1;
        repeat (burst) @(posedge clk);
        stall = idle_cycles();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    string     classic_key;
    key_kind_e kind;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_ROW_ZERO;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    opcode        <= OP_ENCRYPT;
    first_letter  <= '0;
    second_letter <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset square is all A: A is found at the first cell, nothing else is
    send_pair(OP_ENCRYPT, ch("A"), ch("A"));
    send_pair(OP_DECRYPT, ch("A"), ch("A"));
    send_pair(OP_ENCRYPT, ch("A"), ch("Z"));
    send_pair(OP_DECRYPT, ch("Z"), ch("B"));
    settle();

    // classic square without J
    //   P L A Y F / I R E X M / B C D G H / K N O Q S / T U V W Z
    classic_key = "PLAYFIREXMBCDGHKNOQSTUVWZ";
    for (int i = 0; i < CELLS; i++) key_cells[i] = ch(classic_key[i]);
    load_square();
    send_pair(OP_ENCRYPT, ch("P"), ch("F"));   // same row, right edge wraps
    send_pair(OP_DECRYPT, ch("P"), ch("F"));   // same row, left edge wraps
    send_pair(OP_ENCRYPT, ch("P"), ch("T"));   // same column, bottom wraps
    send_pair(OP_DECRYPT, ch("P"), ch("T"));   // same column, top wraps
    send_pair(OP_ENCRYPT, ch("A"), ch("Z"));   // rectangle, lowest and highest code
    send_pair(OP_DECRYPT, ch("Z"), ch("A"));
    send_pair(OP_DECRYPT, ch("M"), ch("B"));   // rectangle
    send_pair(OP_ENCRYPT, ch("E"), ch("E"));   // equal letters take the row rule
    send_pair(OP_DECRYPT, ch("Z"), ch("Z"));
    send_pair(OP_ENCRYPT, ch("J"), ch("A"));   // first letter absent
    send_pair(OP_DECRYPT, ch("A"), ch("J"));   // second letter absent
    send_pair(OP_ENCRYPT, ch("J"), ch("J"));   // both absent
    settle();

    // a write past the last row must leave the square alone
    write_reg(REG_UNUSED, '1);
    cfg_we <= 1'b0;
    send_pair(OP_ENCRYPT, ch("P"), ch("F"));
    send_pair(OP_DECRYPT, ch("M"), ch("B"));
    settle();

    // every entry code 31: no letter can match
    foreach (key_cells[i]) key_cells[i] = '1;
    load_square();
    send_pair(OP_ENCRYPT, ch("A"), ch("Z"));
    send_pair(OP_DECRYPT, ch("Y"), ch("Y"));
    settle();

    // every entry zero, written explicitly
    foreach (key_cells[i]) key_cells[i] = '0;
    load_square();
    send_pair(OP_ENCRYPT, ch("A"), ch("A"));
    send_pair(OP_DECRYPT, ch("A"), ch("B"));
    settle();

    // random squares; the first phase opens with a back-to-back burst while
    // the result side holds off, so the pipeline fills and in_ready drops
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 1)
        kind = KEY_REPEATS;
      else if (p == 2)
        kind = KEY_RAW;
      else
        kind = ($urandom_range(0, 9) < 7) ? KEY_CLASSIC :
               ($urandom_range(0, 1) ? KEY_REPEATS : KEY_RAW);
      pick_square(kind);
      load_square();
      steady_sender = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        steady_sender = 1'b1;
        sink_hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_PAIRS; n++) begin
        if (p == 0 && n == BURST_PAIRS) steady_sender = 1'b0;
        send_random_pair();
      end
      settle();
    end

    if (mismatches == 0 && pending_pairs == 0)
      $display("playfair_digraph_cipher_top verification clean");
    else
      $display("playfair_digraph_cipher_top verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #TIMEOUT_NS;
    $display("playfair_digraph_cipher_top verification failed");
    $finish;
  end

endmodule
